@@ design/sbac_pkg.sv @@
// Shared types and constants for the shadow bitmap access checker.
`timescale 1ns / 1ps
package sbac_pkg;

	localparam int ADDR_W       = 64;
	localparam int CNT_W        = 64;
	localparam int SIZE_W       = 4;
	localparam int WINDOW_W     = 16;
	localparam int BYTES_W      = 4;
	localparam int MAX_ACCESS_BYTES = 8;
	localparam int BIT_OFFSET_W = 3;
	localparam int CFG_INDEX_W  = 8;
	localparam int QUEUE_DEPTH  = 4;
	localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
	localparam int QCOUNT_W     = QPTR_W + 1;
	localparam int IN_TDATA_W   = 88;
	localparam int OUT_TDATA_W  = 200;

	localparam logic [CFG_INDEX_W-1:0] CFG_STACK_LOW  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] CFG_STACK_HIGH = CFG_INDEX_W'(1);
	localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_LOW   = CFG_INDEX_W'(2);
	localparam logic [CFG_INDEX_W-1:0] CFG_HEAP_HIGH  = CFG_INDEX_W'(3);

	typedef enum logic [1:0] {
		REGION_STACK = 2'd0,
		REGION_HEAP  = 2'd1,
		REGION_OTHER = 2'd2
	} region_t;

	// One classified access waiting for the counter update.
	typedef struct packed {
		logic               action;
		region_t            region;
		logic [SIZE_W-1:0]  size;
		logic [BYTES_W-1:0] valid_bytes;
		logic [BYTES_W-1:0] invalid_bytes;
	} access_t;

	// Queue status seen by the two sides.
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

endpackage

@@ design/sbac_front.sv @@
// Front end: range registers, region classification and shadow bit count.
`timescale 1ns / 1ps
module sbac_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	input  logic [sbac_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  logic [sbac_pkg::CNT_W-1:0]         cfg_data,
	input  logic                               action,
	input  logic [sbac_pkg::ADDR_W-1:0]        address,
	input  logic [sbac_pkg::SIZE_W-1:0]        access_size,
	input  logic [sbac_pkg::WINDOW_W-1:0]      shadow_window,
	output sbac_pkg::access_t                  entry
);
	import sbac_pkg::*;

	logic [ADDR_W-1:0] stack_low_q, stack_high_q, heap_low_q, heap_high_q;
	logic [SIZE_W-1:0] size_sat;
	logic [WINDOW_W-1:0] shifted;
	logic [BYTES_W-1:0] set_count;
	logic in_stack, in_heap;
	region_t region;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_low_q  <= '0;
			stack_high_q <= '0;
			heap_low_q   <= '0;
			heap_high_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_STACK_LOW:  stack_low_q  <= cfg_data;
				CFG_STACK_HIGH: stack_high_q <= cfg_data;
				CFG_HEAP_LOW:   heap_low_q   <= cfg_data;
				CFG_HEAP_HIGH:  heap_high_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stack = (address > stack_low_q) && (address < stack_high_q);
	assign in_heap  = (address > heap_low_q) && (address < heap_high_q);

	always_comb begin
		if (in_stack) begin
			region = REGION_STACK;
		end else if (in_heap) begin
			region = REGION_HEAP;
		end else begin
			region = REGION_OTHER;
		end
	end

	assign size_sat = (access_size > SIZE_W'(MAX_ACCESS_BYTES)) ?
		SIZE_W'(MAX_ACCESS_BYTES) : access_size;

	// Byte i of the access has its shadow bit at window position offset + i.
	assign shifted = shadow_window >> address[BIT_OFFSET_W-1:0];

	always_comb begin
		set_count = '0;
		for (int i = 0; i < MAX_ACCESS_BYTES; i++) begin
			if ((SIZE_W'(i) < size_sat) && shifted[i]) begin
				set_count = set_count + BYTES_W'(1);
			end
		end
	end

	always_comb begin
		entry.action = action;
		entry.region = region;
		entry.size   = size_sat;
		if (region == REGION_HEAP) begin
			entry.valid_bytes   = set_count;
			entry.invalid_bytes = BYTES_W'(size_sat) - set_count;
		end else begin
			entry.valid_bytes   = '0;
			entry.invalid_bytes = '0;
		end
	end

endmodule

@@ design/sbac_queue.sv @@
// Short queue of classified accesses between the front and back ends.
`timescale 1ns / 1ps
module sbac_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    push,
	input  sbac_pkg::access_t       push_data,
	input  logic                    pop,
	output sbac_pkg::access_t       pop_data,
	output sbac_pkg::queue_status_t status
);
	import sbac_pkg::*;

	access_t entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;
	logic do_push, do_pop;

	assign status.full  = (count_q == QCOUNT_W'(QUEUE_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push = push && !status.full;
	assign do_pop  = pop && !status.empty;
	assign pop_data = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + QCOUNT_W'(1);
				2'b01:   count_q <= count_q - QCOUNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ design/sbac_back.sv @@
// Back end: byte counters per region and direction, heap shadow counters, result register.
`timescale 1ns / 1ps
module sbac_back (
	input  logic                            clk,
	input  logic                            arst_n,
	input  sbac_pkg::access_t               entry,
	input  logic                            entry_avail,
	output logic                            entry_take,
	output logic                            out_valid,
	input  logic                            out_ready,
	output sbac_pkg::region_t               out_region,
	output logic [sbac_pkg::BYTES_W-1:0]    out_valid_bytes,
	output logic [sbac_pkg::BYTES_W-1:0]    out_invalid_bytes,
	output logic [sbac_pkg::CNT_W-1:0]      out_region_total,
	output logic [sbac_pkg::CNT_W-1:0]      out_valid_total,
	output logic [sbac_pkg::CNT_W-1:0]      out_invalid_total
);
	import sbac_pkg::*;

	logic [CNT_W-1:0] stack_cnt_q [2];
	logic [CNT_W-1:0] heap_cnt_q  [2];
	logic [CNT_W-1:0] other_cnt_q [2];
	logic [CNT_W-1:0] valid_cnt_q [2];
	logic [CNT_W-1:0] invalid_cnt_q [2];
	logic [CNT_W-1:0] region_sum, valid_sum, invalid_sum;
	logic out_valid_q;

	// The result register frees up whenever its beat is taken.
	assign entry_take = entry_avail && (!out_valid_q || out_ready);
	assign out_valid  = out_valid_q;

	always_comb begin
		case (entry.region)
			REGION_STACK: region_sum = stack_cnt_q[entry.action];
			REGION_HEAP:  region_sum = heap_cnt_q[entry.action];
			default:      region_sum = other_cnt_q[entry.action];
		endcase
		region_sum  = region_sum + CNT_W'(entry.size);
		valid_sum   = valid_cnt_q[entry.action] + CNT_W'(entry.valid_bytes);
		invalid_sum = invalid_cnt_q[entry.action] + CNT_W'(entry.invalid_bytes);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int d = 0; d < 2; d++) begin
				stack_cnt_q[d]   <= '0;
				heap_cnt_q[d]    <= '0;
				other_cnt_q[d]   <= '0;
				valid_cnt_q[d]   <= '0;
				invalid_cnt_q[d] <= '0;
			end
		end else begin
			if (entry_take) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (entry_take) begin
				case (entry.region)
					REGION_STACK: stack_cnt_q[entry.action] <= region_sum;
					REGION_HEAP:  heap_cnt_q[entry.action]  <= region_sum;
					default:      other_cnt_q[entry.action] <= region_sum;
				endcase
				valid_cnt_q[entry.action]   <= valid_sum;
				invalid_cnt_q[entry.action] <= invalid_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (entry_take) begin
			out_region        <= entry.region;
			out_valid_bytes   <= entry.valid_bytes;
			out_invalid_bytes <= entry.invalid_bytes;
			out_region_total  <= region_sum;
			out_valid_total   <= valid_sum;
			out_invalid_total <= invalid_sum;
		end
	end

endmodule

@@ design/shadow_bitmap_access_checker_core.sv @@
// Top level of the shadow bitmap access checker.
// An accepted beat passes through the queue and then the result register to the output.
// One access per cycle is taken while the queue has room and retired while unstalled.
// The four-entry queue lets the input keep taking beats while the output is stalled.
// Reset clears the range registers, all byte and shadow counters, and the queue.
`timescale 1ns / 1ps
module shadow_bitmap_access_checker_core (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [sbac_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [sbac_pkg::CNT_W-1:0]            cfg_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// [63:0] address, [67:64] access_size, [83:68] shadow_window, [87:84] zero
	input  logic [sbac_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
	// [0] action
	input  logic                                  s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// [3:0] valid_bytes, [7:4] invalid_bytes, [71:8] region_total,
	// [135:72] valid_total, [199:136] invalid_total
	output logic [sbac_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
	// [1:0] region
	output logic [1:0]                            m_axis_tuser
);
	import sbac_pkg::*;

	access_t front_entry, queue_head;
	queue_status_t qstat;
	logic push, take;
	region_t out_region;
	logic [BYTES_W-1:0] out_valid_bytes, out_invalid_bytes;
	logic [CNT_W-1:0] out_region_total, out_valid_total, out_invalid_total;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !qstat.full;
	assign push          = s_axis_tvalid && s_axis_tready;

	sbac_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (s_axis_tuser),
		.address       (s_axis_tdata[63:0]),
		.access_size   (s_axis_tdata[67:64]),
		.shadow_window (s_axis_tdata[83:68]),
		.entry         (front_entry)
	);

	sbac_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (front_entry),
		.pop       (take),
		.pop_data  (queue_head),
		.status    (qstat)
	);

	sbac_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.entry             (queue_head),
		.entry_avail       (!qstat.empty),
		.entry_take        (take),
		.out_valid         (m_axis_tvalid),
		.out_ready         (m_axis_tready),
		.out_region        (out_region),
		.out_valid_bytes   (out_valid_bytes),
		.out_invalid_bytes (out_invalid_bytes),
		.out_region_total  (out_region_total),
		.out_valid_total   (out_valid_total),
		.out_invalid_total (out_invalid_total)
	);

	assign m_axis_tuser = out_region;
	assign m_axis_tdata = {out_invalid_total, out_valid_total, out_region_total,
		out_invalid_bytes, out_valid_bytes};

	// Input is refused only when the queue is full.
	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> qstat.full)
		else $error("input stalled with queue space left");

	// Shadow counts are zero for every access outside the heap.
	a_nonheap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (out_region != REGION_HEAP)) |->
		((out_valid_bytes == '0) && (out_invalid_bytes == '0)))
		else $error("shadow counts on a non-heap result");

	// Valid and invalid bytes never exceed the largest access.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
		((5'(out_valid_bytes) + 5'(out_invalid_bytes)) <= 5'(MAX_ACCESS_BYTES)))
		else $error("shadow counts exceed access size");

	// A queued access reaches the output register when it is free.
	a_retire: assert property (@(posedge clk) disable iff (!arst_n)
		(!qstat.empty && (!m_axis_tvalid || m_axis_tready)) |=> m_axis_tvalid)
		else $error("queued access not retired");

endmodule
